>>> rtl/lag_pkg.sv
// Shared types and constants for the life automaton generation block.
`timescale 1ns / 1ps

package lag_pkg;

   // command codes carried by req_command
   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_STEP  = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   // configuration register indexes
   localparam logic [1:0] CSR_WIDTH_IN_USE  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT_IN_USE = 2'd1;
   localparam logic [1:0] CSR_GEN_LIMIT     = 2'd2;

   // configuration reset values
   localparam logic [6:0]  WIDTH_RESET     = 7'd64;
   localparam logic [6:0]  HEIGHT_RESET    = 7'd64;
   localparam logic [15:0] GEN_LIMIT_RESET = 16'd1000;

   // saturation point of the generation count
   localparam logic [15:0] GEN_MAX = 16'hFFFF;

   // B3/S23 neighbour counts
   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

endpackage

>>> rtl/lag_cell_rule.sv
// One cell of the B3/S23 update: neighbour count and next state.
`timescale 1ns / 1ps

module lag_cell_rule (
   input  logic [7:0] neighbours,
   input  logic       alive,
   output logic       next_alive
);
   import lag_pkg::*;

   logic [3:0] count;

   // count live neighbours and apply birth on three, survival on two or three
   always_comb begin
      count      = 4'($countones(neighbours));
      next_alive = (count == BIRTH_COUNT) || (alive && (count == SURVIVE_COUNT));
   end

endmodule

>>> rtl/lag_row_stage.sv
// One row of the grid: a stage of the rotating row ring.
`timescale 1ns / 1ps

module lag_row_stage #(
   parameter int COLS = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            shift,
   input  logic [COLS-1:0] row_d,
   output logic [COLS-1:0] row_q
);

   logic [COLS-1:0] row_ff;
   logic [COLS-1:0] row_in;

   // take the neighbour's row while the ring turns, hold otherwise
   always_comb begin
      row_in = shift ? row_d : row_ff;
   end

   // clear to dead at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else begin
         row_ff <= row_in;
      end
   end

   assign row_q = row_ff;

endmodule

>>> rtl/life_automaton_generation.sv
// Top level: row ring grid, per-row B3/S23 update, command sequencing.
// Every command turns the row ring once, one row per cycle.
// rsp_valid is registered from the last row of the revolution.
// A new command is accepted only while busy is low, once the revolution is done.
// The receiver cannot stall; each result is strobed for a single cycle.
// Reset clears every cell to dead at once, zeroes the count, restores the registers.
`timescale 1ns / 1ps

module life_automaton_generation #(
   parameter int GRID_COLS = 64,
   parameter int GRID_ROWS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [5:0]  req_col,
   input  logic [5:0]  req_row,
   input  logic        req_cell_value,
   output logic        rsp_valid,
   output logic        rsp_cell_state,
   output logic        rsp_changed,
   output logic        rsp_keep_running,
   output logic [15:0] rsp_generation,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import lag_pkg::*;

   localparam int CCW = $clog2(GRID_COLS + 1);
   localparam int RCW = $clog2(GRID_ROWS + 1);
   localparam int EW  = (CCW > 7) ? CCW : 7;
   localparam int HW  = (RCW > 7) ? RCW : 7;
   localparam logic [EW-1:0] COLS_E = EW'(GRID_COLS);
   localparam logic [HW-1:0] ROWS_H = HW'(GRID_ROWS);
   localparam logic [HW-1:0] LAST_ROW = HW'(GRID_ROWS - 1);

   // configuration registers
   logic [6:0]  width_ff, width_in;
   logic [6:0]  height_ff, height_in;
   logic [15:0] limit_ff, limit_in;

   // command control
   logic          busy_ff, busy_in;
   logic [HW-1:0] t_ff, t_in;
   cmd_type       cmd_ff, cmd_in;
   logic [5:0]    col_ff, col_in;
   logic [5:0]    row_ff, row_in;
   logic          val_ff, val_in;
   logic [15:0]   gen_ff, gen_in;
   logic          chg_ff, chg_in;
   logic          cell_ff, cell_in;
   logic [GRID_COLS-1:0] prev_ff, prev_in;

   // result registers
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_cell_ff, rsp_cell_in;
   logic        rsp_chg_ff, rsp_chg_in;
   logic        rsp_run_ff, rsp_run_in;
   logic [15:0] rsp_gen_ff, rsp_gen_in;

   // ring and row logic
   logic [GRID_COLS-1:0] ring_q [GRID_ROWS];
   logic [GRID_COLS-1:0] tail_row;
   logic [GRID_COLS-1:0] col_mask;
   logic [GRID_COLS-1:0] col_hot;
   logic [GRID_COLS-1:0] cur_row, down_row, new_row;
   logic [GRID_COLS+1:0] up_pad, cur_pad, down_pad;
   logic [EW-1:0]        w_eff;
   logic [HW-1:0]        h_eff;
   logic                 accept, last, row_live, down_live, hit, in_range;

   assign accept    = start && !busy_ff;
   assign last      = busy_ff && (t_ff == LAST_ROW);
   assign csr_ready = 1'b1;

   // clamp the area in use to the grid
   always_comb begin
      w_eff = (EW'(width_ff) > COLS_E) ? COLS_E : EW'(width_ff);
      h_eff = (HW'(height_ff) > ROWS_H) ? ROWS_H : HW'(height_ff);
   end

   // column enables and the addressed column
   for (genvar c = 0; c < GRID_COLS; c++) begin : g_cols
      assign col_mask[c] = EW'(c) < w_eff;
      assign col_hot[c]  = EW'(col_ff) == EW'(c);
   end

   // window rows around the head row, padded with dead edge cells
   always_comb begin
      row_live  = t_ff < h_eff;
      down_live = (t_ff + HW'(1)) < h_eff;
      cur_row   = ring_q[0] & col_mask;
      down_row  = down_live ? (ring_q[1] & col_mask) : '0;
      up_pad    = {1'b0, prev_ff, 1'b0};
      cur_pad   = {1'b0, cur_row, 1'b0};
      down_pad  = {1'b0, down_row, 1'b0};
   end

   // one rule cell per column
   for (genvar c = 0; c < GRID_COLS; c++) begin : g_rule
      lag_cell_rule u_rule (
         .neighbours ({up_pad[c], up_pad[c+1], up_pad[c+2],
                       cur_pad[c], cur_pad[c+2],
                       down_pad[c], down_pad[c+1], down_pad[c+2]}),
         .alive      (cur_row[c]),
         .next_alive (new_row[c])
      );
   end

   // row that re-enters the ring at the tail
   always_comb begin
      hit      = (HW'(row_ff) == t_ff);
      in_range = row_live && ((col_hot & col_mask) != '0);
      tail_row = ring_q[0];
      case (cmd_ff)
         CMD_STEP: begin
            if (row_live) begin
               tail_row = (new_row & col_mask) | (ring_q[0] & ~col_mask);
            end
         end
         CMD_WRITE: begin
            if (hit && in_range) begin
               tail_row = val_ff ? (ring_q[0] | col_hot) : (ring_q[0] & ~col_hot);
            end
         end
         default: begin
            tail_row = ring_q[0];
         end
      endcase
   end

   // rotating ring of row stages
   for (genvar r = 0; r < GRID_ROWS; r++) begin : g_ring
      if (r == GRID_ROWS - 1) begin : g_tail
         lag_row_stage #(.COLS(GRID_COLS)) u_stage (
            .clock (clock),
            .reset (reset),
            .shift (busy_ff),
            .row_d (tail_row),
            .row_q (ring_q[r])
         );
      end else begin : g_body
         lag_row_stage #(.COLS(GRID_COLS)) u_stage (
            .clock (clock),
            .reset (reset),
            .shift (busy_ff),
            .row_d (ring_q[r+1]),
            .row_q (ring_q[r])
         );
      end
   end

   // configuration writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      limit_in  = limit_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_WIDTH_IN_USE:  width_in  = csr_data[6:0];
            CSR_HEIGHT_IN_USE: height_in = csr_data[6:0];
            CSR_GEN_LIMIT:     limit_in  = csr_data;
            default:           limit_in  = limit_ff;
         endcase
      end
   end

   // command sequencing across one ring revolution
   always_comb begin
      busy_in = busy_ff;
      t_in    = t_ff;
      cmd_in  = cmd_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      val_in  = val_ff;
      gen_in  = gen_ff;
      chg_in  = chg_ff;
      cell_in = cell_ff;
      prev_in = prev_ff;
      if (accept) begin
         busy_in = 1'b1;
         t_in    = '0;
         cmd_in  = cmd_type'(req_command);
         col_in  = req_col;
         row_in  = req_row;
         val_in  = req_cell_value;
         chg_in  = 1'b0;
         cell_in = 1'b0;
         prev_in = '0;
         if ((cmd_type'(req_command) == CMD_STEP) && (gen_ff != GEN_MAX)) begin
            gen_in = gen_ff + 16'd1;
         end
      end else if (busy_ff) begin
         t_in    = t_ff + HW'(1);
         prev_in = cur_row;
         if (last) begin
            busy_in = 1'b0;
         end
         if ((cmd_ff == CMD_STEP) && row_live && (((new_row ^ cur_row) & col_mask) != '0)) begin
            chg_in = 1'b1;
         end
         if ((cmd_ff == CMD_READ) && hit && in_range) begin
            cell_in = ((ring_q[0] & col_hot) != '0);
         end
      end
   end

   // results at the end of the revolution
   always_comb begin
      rsp_valid_in = last;
      rsp_cell_in  = rsp_cell_ff;
      rsp_chg_in   = rsp_chg_ff;
      rsp_run_in   = rsp_run_ff;
      rsp_gen_in   = rsp_gen_ff;
      if (last) begin
         rsp_cell_in = cell_in;
         rsp_chg_in  = chg_in;
         rsp_run_in  = chg_in && (gen_ff <= limit_ff);
         rsp_gen_in  = gen_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         limit_ff     <= GEN_LIMIT_RESET;
         busy_ff      <= 1'b0;
         t_ff         <= '0;
         gen_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         limit_ff     <= limit_in;
         busy_ff      <= busy_in;
         t_ff         <= t_in;
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload state
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      col_ff     <= col_in;
      row_ff     <= row_in;
      val_ff     <= val_in;
      chg_ff     <= chg_in;
      cell_ff    <= cell_in;
      prev_ff    <= prev_in;
      rsp_cell_ff <= rsp_cell_in;
      rsp_chg_ff  <= rsp_chg_in;
      rsp_run_ff  <= rsp_run_in;
      rsp_gen_ff  <= rsp_gen_in;
   end

   assign busy             = busy_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cell_state   = rsp_cell_ff;
   assign rsp_changed      = rsp_chg_ff;
   assign rsp_keep_running = rsp_run_ff;
   assign rsp_generation   = rsp_gen_ff;

endmodule
